FILE: hw/rtl/erm_pkg.sv
// Shared constants and elaboration-time sine table functions for the Euler rotation matrix.
package erm_pkg;

   localparam int OUT_W = 16;

   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;
   localparam int N_AXIS = 3;

   // first-level product slots
   localparam int P_SYSX = 0;
   localparam int P_CZCX = 1;
   localparam int P_SZCX = 2;
   localparam int P_CZCY = 3;
   localparam int P_SZCY = 4;
   localparam int P_SZSX = 5;
   localparam int P_CZSX = 6;
   localparam int P_CYSX = 7;
   localparam int P_CYCX = 8;
   localparam int N_PROD = 9;

   localparam int N_ENTRY = 9;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

   // floor(a*b / 2^s), low 64 bits
   function automatic logic [63:0] umulshr(logic [63:0] a, logic [63:0] b, int unsigned s);
      logic [127:0] p;
      logic [127:0] t;
      p = {64'd0, a} * {64'd0, b};
      t = p >> s;
      return t[63:0];
   endfunction

   // shift-subtract division, divisor stays far below 2^63
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         if (r >= den) begin
            r = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Taylor series of sin, Q60 in and out, 0 <= x <= pi/2
   function automatic logic [63:0] sin_q60(logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] den;
      x2 = umulshr(x, x, 60);
      term = x;
      sum = x;
      for (int n = 1; n <= 15; n++) begin
         den = 64'((2 * n) * (2 * n + 1));
         term = udiv64(umulshr(term, x2, 60), den);
         if ((n % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // magnitude of sin(2*pi*k/2^angle_bits) with frac_bits fraction bits, rounded
   function automatic logic [63:0] sine_mag(int unsigned k, int unsigned angle_bits,
                                            int unsigned frac_bits);
      logic [63:0] theta;
      logic [63:0] s;
      logic [63:0] one;
      one = 64'd1;
      if (k == 0) begin
         return 64'd0;
      end
      theta = umulshr(PI_Q60, 64'(k), angle_bits - 1);
      s = sin_q60(theta);
      return (s + (one << (59 - frac_bits))) >> (60 - frac_bits);
   endfunction

endpackage

FILE: hw/rtl/erm_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module erm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: hw/rtl/erm_lookup.sv
// Sine/cosine lookup: quarter-wave RAMs filled after reset, two pipeline stages.
module erm_lookup #(
   parameter int ANGLE_BITS = 12,
   parameter int FRAC_BITS  = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [ANGLE_BITS-1:0]       angle [erm_pkg::N_AXIS],
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [FRAC_BITS+1:0] sin_val [erm_pkg::N_AXIS],
   output logic signed [FRAC_BITS+1:0] cos_val [erm_pkg::N_AXIS]
);

   localparam int K_W     = ANGLE_BITS - 1;
   localparam int MAG_W   = FRAC_BITS + 1;
   localparam int R_W     = FRAC_BITS + 2;
   localparam int N_TBL   = (1 << (ANGLE_BITS - 2)) + 1;
   localparam int TBL_W   = N_TBL * MAG_W;
   localparam logic [K_W-1:0] QUARTER = K_W'(1) << (ANGLE_BITS - 2);

   function automatic logic [TBL_W-1:0] build_table();
      logic [TBL_W-1:0] tbl;
      tbl = '0;
      for (int k = 0; k < N_TBL; k++) begin
         tbl[k*MAG_W +: MAG_W] = MAG_W'(erm_pkg::sine_mag(k, ANGLE_BITS, FRAC_BITS));
      end
      return tbl;
   endfunction

   localparam logic [TBL_W-1:0] SINE_TABLE = build_table();

   // fill sequencer
   logic             fill_run_ff;
   logic             fill_run_in;
   logic [K_W-1:0]   fill_cnt_ff;
   logic [K_W-1:0]   fill_cnt_in;
   logic             wr_en_ff;
   logic             wr_en_in;
   logic [K_W-1:0]   wr_addr_ff;
   logic [MAG_W-1:0] wr_data_ff;

   always_comb begin
      fill_run_in = fill_run_ff;
      fill_cnt_in = fill_cnt_ff;
      wr_en_in    = fill_run_ff;
      if (fill_run_ff) begin
         fill_cnt_in = fill_cnt_ff + K_W'(1);
         if (fill_cnt_ff == QUARTER) begin
            fill_run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_run_ff <= 1'b1;
         fill_cnt_ff <= '0;
         wr_en_ff    <= 1'b0;
      end else begin
         fill_run_ff <= fill_run_in;
         fill_cnt_ff <= fill_cnt_in;
         wr_en_ff    <= wr_en_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= fill_cnt_ff;
      wr_data_ff <= SINE_TABLE[fill_cnt_ff*MAG_W +: MAG_W];
   end

   // stage handshake
   logic lv1_ff;
   logic lv1_in;
   logic lv2_ff;
   logic adv1;
   logic adv2;

   assign adv2     = !lv2_ff || out_ready;
   assign adv1     = !lv1_ff || adv2;
   assign in_ready = adv1 && !fill_run_ff && !wr_en_ff;
   assign lv1_in   = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lv1_ff <= 1'b0;
         lv2_ff <= 1'b0;
      end else begin
         if (adv1) begin
            lv1_ff <= lv1_in;
         end
         if (adv2) begin
            lv2_ff <= lv1_ff;
         end
      end
   end

   // address and sign per axis; cosine is the sine a quarter turn on
   logic [K_W-1:0] addr_s [erm_pkg::N_AXIS];
   logic [K_W-1:0] addr_c [erm_pkg::N_AXIS];
   logic [1:0]     sgn_in [erm_pkg::N_AXIS];
   logic [1:0]     sgn_ff [erm_pkg::N_AXIS];
   logic [MAG_W-1:0] mag_s [erm_pkg::N_AXIS];
   logic [MAG_W-1:0] mag_c [erm_pkg::N_AXIS];
   logic signed [R_W-1:0] sin_ff [erm_pkg::N_AXIS];
   logic signed [R_W-1:0] cos_ff [erm_pkg::N_AXIS];

   always_comb begin
      for (int a = 0; a < erm_pkg::N_AXIS; a++) begin
         logic [1:0]     q;
         logic [K_W-1:0] r;
         q = angle[a][ANGLE_BITS-1 -: 2];
         r = {1'b0, angle[a][ANGLE_BITS-3:0]};
         addr_s[a] = q[0] ? (QUARTER - r) : r;
         addr_c[a] = q[0] ? r : (QUARTER - r);
         sgn_in[a] = {q[1] ^ q[0], q[1]};
      end
   end

   for (genvar g = 0; g < erm_pkg::N_AXIS; g++) begin : g_axis
      erm_ram #(
         .WIDTH(MAG_W),
         .DEPTH(N_TBL)
      ) u_ram (
         .clock    (clock),
         .wr_en    (wr_en_ff),
         .wr_addr  (wr_addr_ff),
         .wr_data  (wr_data_ff),
         .rd_en    (adv1),
         .rd_addr_a(addr_s[g]),
         .rd_addr_b(addr_c[g]),
         .rd_data_a(mag_s[g]),
         .rd_data_b(mag_c[g])
      );
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         sgn_ff <= sgn_in;
      end
      if (adv2) begin
         for (int a = 0; a < erm_pkg::N_AXIS; a++) begin
            sin_ff[a] <= sgn_ff[a][0] ? -$signed({1'b0, mag_s[a]}) : $signed({1'b0, mag_s[a]});
            cos_ff[a] <= sgn_ff[a][1] ? -$signed({1'b0, mag_c[a]}) : $signed({1'b0, mag_c[a]});
         end
      end
   end

   assign out_valid = lv2_ff;
   assign sin_val   = sin_ff;
   assign cos_val   = cos_ff;

endmodule

FILE: hw/rtl/erm_prod1.sv
// First-level products of sines and cosines: multiply stage, then round stage.
module erm_prod1 #(
   parameter int FRAC_BITS = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [FRAC_BITS+1:0] sin_val [erm_pkg::N_AXIS],
   input  logic signed [FRAC_BITS+1:0] cos_val [erm_pkg::N_AXIS],
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [FRAC_BITS+1:0] prod [erm_pkg::N_PROD],
   output logic signed [FRAC_BITS+1:0] sy,
   output logic signed [FRAC_BITS+1:0] cz,
   output logic signed [FRAC_BITS+1:0] sz
);

   localparam int R_W = FRAC_BITS + 2;
   localparam int P_W = 2 * FRAC_BITS + 4;
   localparam logic signed [P_W-1:0] HALF = P_W'(1) << (FRAC_BITS - 1);

   logic lv1_ff;
   logic lv2_ff;
   logic adv1;
   logic adv2;

   assign adv2     = !lv2_ff || out_ready;
   assign adv1     = !lv1_ff || adv2;
   assign in_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lv1_ff <= 1'b0;
         lv2_ff <= 1'b0;
      end else begin
         if (adv1) begin
            lv1_ff <= in_valid;
         end
         if (adv2) begin
            lv2_ff <= lv1_ff;
         end
      end
   end

   logic signed [P_W-1:0] raw_in [erm_pkg::N_PROD];
   logic signed [P_W-1:0] raw_ff [erm_pkg::N_PROD];
   logic signed [R_W-1:0] rnd_in [erm_pkg::N_PROD];
   logic signed [R_W-1:0] rnd_ff [erm_pkg::N_PROD];
   logic signed [R_W-1:0] sy1_ff, cz1_ff, sz1_ff;
   logic signed [R_W-1:0] sy2_ff, cz2_ff, sz2_ff;

   always_comb begin
      raw_in[erm_pkg::P_SYSX] = sin_val[erm_pkg::AXIS_Y] * sin_val[erm_pkg::AXIS_X];
      raw_in[erm_pkg::P_CZCX] = cos_val[erm_pkg::AXIS_Z] * cos_val[erm_pkg::AXIS_X];
      raw_in[erm_pkg::P_SZCX] = sin_val[erm_pkg::AXIS_Z] * cos_val[erm_pkg::AXIS_X];
      raw_in[erm_pkg::P_CZCY] = cos_val[erm_pkg::AXIS_Z] * cos_val[erm_pkg::AXIS_Y];
      raw_in[erm_pkg::P_SZCY] = sin_val[erm_pkg::AXIS_Z] * cos_val[erm_pkg::AXIS_Y];
      raw_in[erm_pkg::P_SZSX] = sin_val[erm_pkg::AXIS_Z] * sin_val[erm_pkg::AXIS_X];
      raw_in[erm_pkg::P_CZSX] = cos_val[erm_pkg::AXIS_Z] * sin_val[erm_pkg::AXIS_X];
      raw_in[erm_pkg::P_CYSX] = cos_val[erm_pkg::AXIS_Y] * sin_val[erm_pkg::AXIS_X];
      raw_in[erm_pkg::P_CYCX] = cos_val[erm_pkg::AXIS_Y] * cos_val[erm_pkg::AXIS_X];
   end

   // round half up: floor((p + half) / 2^frac)
   always_comb begin
      for (int i = 0; i < erm_pkg::N_PROD; i++) begin
         rnd_in[i] = R_W'((raw_ff[i] + HALF) >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         raw_ff <= raw_in;
         sy1_ff <= sin_val[erm_pkg::AXIS_Y];
         cz1_ff <= cos_val[erm_pkg::AXIS_Z];
         sz1_ff <= sin_val[erm_pkg::AXIS_Z];
      end
      if (adv2) begin
         rnd_ff <= rnd_in;
         sy2_ff <= sy1_ff;
         cz2_ff <= cz1_ff;
         sz2_ff <= sz1_ff;
      end
   end

   assign out_valid = lv2_ff;
   assign prod      = rnd_ff;
   assign sy        = sy2_ff;
   assign cz        = cz2_ff;
   assign sz        = sz2_ff;

endmodule

FILE: hw/rtl/erm_prod2.sv
// Second-level products, final sums and saturation into the nine matrix entries.
module erm_prod2 #(
   parameter int FRAC_BITS = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [FRAC_BITS+1:0]      prod [erm_pkg::N_PROD],
   input  logic signed [FRAC_BITS+1:0]      sy,
   input  logic signed [FRAC_BITS+1:0]      cz,
   input  logic signed [FRAC_BITS+1:0]      sz,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [erm_pkg::OUT_W-1:0] entry [erm_pkg::N_ENTRY]
);

   localparam int R_W   = FRAC_BITS + 2;
   localparam int P_W   = 2 * FRAC_BITS + 4;
   localparam int S_W   = FRAC_BITS + 3;
   localparam int EXT_W = (S_W > erm_pkg::OUT_W) ? S_W : erm_pkg::OUT_W;
   localparam logic signed [P_W-1:0]   HALF    = P_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [EXT_W-1:0] ONE     = EXT_W'(1) << FRAC_BITS;
   localparam logic signed [EXT_W-1:0] NEG_ONE = -ONE;

   function automatic logic signed [R_W-1:0] round_q(logic signed [P_W-1:0] p);
      return R_W'((p + HALF) >>> FRAC_BITS);
   endfunction

   function automatic logic signed [erm_pkg::OUT_W-1:0] sat_out(logic signed [S_W-1:0] v);
      logic signed [EXT_W-1:0] w;
      w = EXT_W'(v);
      if (w > ONE) begin
         w = ONE;
      end else if (w < NEG_ONE) begin
         w = NEG_ONE;
      end
      return w[erm_pkg::OUT_W-1:0];
   endfunction

   logic lv1_ff;
   logic lv2_ff;
   logic adv1;
   logic adv2;

   assign adv2     = !lv2_ff || out_ready;
   assign adv1     = !lv1_ff || adv2;
   assign in_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lv1_ff <= 1'b0;
         lv2_ff <= 1'b0;
      end else begin
         if (adv1) begin
            lv1_ff <= in_valid;
         end
         if (adv2) begin
            lv2_ff <= lv1_ff;
         end
      end
   end

   logic signed [P_W-1:0] czsysx_ff, czcxsy_ff, szsysx_ff, szcxsy_ff;
   logic signed [R_W-1:0] prod_ff [erm_pkg::N_PROD];
   logic signed [R_W-1:0] sy_ff;
   logic signed [erm_pkg::OUT_W-1:0] entry_in [erm_pkg::N_ENTRY];
   logic signed [erm_pkg::OUT_W-1:0] entry_ff [erm_pkg::N_ENTRY];

   always_ff @(posedge clock) begin
      if (adv1) begin
         czsysx_ff <= cz * prod[erm_pkg::P_SYSX];
         czcxsy_ff <= prod[erm_pkg::P_CZCX] * sy;
         szsysx_ff <= sz * prod[erm_pkg::P_SYSX];
         szcxsy_ff <= prod[erm_pkg::P_SZCX] * sy;
         prod_ff   <= prod;
         sy_ff     <= sy;
      end
      if (adv2) begin
         entry_ff <= entry_in;
      end
   end

   always_comb begin
      entry_in[0] = sat_out(S_W'(prod_ff[erm_pkg::P_CZCY]));
      entry_in[1] = sat_out(S_W'(round_q(czsysx_ff)) - S_W'(prod_ff[erm_pkg::P_SZCX]));
      entry_in[2] = sat_out(S_W'(round_q(czcxsy_ff)) + S_W'(prod_ff[erm_pkg::P_SZSX]));
      entry_in[3] = sat_out(S_W'(prod_ff[erm_pkg::P_SZCY]));
      entry_in[4] = sat_out(S_W'(prod_ff[erm_pkg::P_CZCX]) + S_W'(round_q(szsysx_ff)));
      entry_in[5] = sat_out(S_W'(round_q(szcxsy_ff)) - S_W'(prod_ff[erm_pkg::P_CZSX]));
      entry_in[6] = sat_out(-S_W'(sy_ff));
      entry_in[7] = sat_out(S_W'(prod_ff[erm_pkg::P_CYSX]));
      entry_in[8] = sat_out(S_W'(prod_ff[erm_pkg::P_CYCX]));
   end

   assign out_valid = lv2_ff;
   assign entry     = entry_ff;

endmodule

FILE: hw/rtl/euler_rotation_matrix.sv
// Top level of the fixed-point Euler angle (z, y, x) rotation matrix pipeline.
// Takes three angles (full turn = 2^ANGLE_BITS) and returns the nine entries of
// R = Rz * Ry * Rx in signed Q1.FRAC_BITS, each saturated to +-1.0 and given as
// 16-bit two's complement. One item enters per cycle while req_ready is high
// (it drops during the table fill and when a full pipeline stalls); each item
// passes through the sine/cosine RAM read and sign, the first products and
// their rounding, and the second products, sums and saturation; the final stage
// is the output register. Each stage holds its item while the next is full, so
// bubbles close up when the output stalls. After reset the quarter-wave sine
// RAMs are loaded from a constant table, one entry a cycle, and req_ready stays
// low until the last entry is written.
module euler_rotation_matrix #(
   parameter int ANGLE_BITS = 12,
   parameter int FRAC_BITS  = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [ANGLE_BITS-1:0]            req_angle_x,
   input  logic [ANGLE_BITS-1:0]            req_angle_y,
   input  logic [ANGLE_BITS-1:0]            req_angle_z,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [erm_pkg::OUT_W-1:0] rsp_m_row0_col0,
   output logic signed [erm_pkg::OUT_W-1:0] rsp_m_row0_col1,
   output logic signed [erm_pkg::OUT_W-1:0] rsp_m_row0_col2,
   output logic signed [erm_pkg::OUT_W-1:0] rsp_m_row1_col0,
   output logic signed [erm_pkg::OUT_W-1:0] rsp_m_row1_col1,
   output logic signed [erm_pkg::OUT_W-1:0] rsp_m_row1_col2,
   output logic signed [erm_pkg::OUT_W-1:0] rsp_m_row2_col0,
   output logic signed [erm_pkg::OUT_W-1:0] rsp_m_row2_col1,
   output logic signed [erm_pkg::OUT_W-1:0] rsp_m_row2_col2
);

   localparam int R_W = FRAC_BITS + 2;

   logic [ANGLE_BITS-1:0] angle [erm_pkg::N_AXIS];

   assign angle[erm_pkg::AXIS_X] = req_angle_x;
   assign angle[erm_pkg::AXIS_Y] = req_angle_y;
   assign angle[erm_pkg::AXIS_Z] = req_angle_z;

   logic                  trig_valid;
   logic                  trig_ready;
   logic signed [R_W-1:0] sin_val [erm_pkg::N_AXIS];
   logic signed [R_W-1:0] cos_val [erm_pkg::N_AXIS];

   erm_lookup #(
      .ANGLE_BITS(ANGLE_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_lookup (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .angle    (angle),
      .out_valid(trig_valid),
      .out_ready(trig_ready),
      .sin_val  (sin_val),
      .cos_val  (cos_val)
   );

   logic                  p1_valid;
   logic                  p1_ready;
   logic signed [R_W-1:0] prod [erm_pkg::N_PROD];
   logic signed [R_W-1:0] sy;
   logic signed [R_W-1:0] cz;
   logic signed [R_W-1:0] sz;

   erm_prod1 #(
      .FRAC_BITS(FRAC_BITS)
   ) u_prod1 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (trig_valid),
      .in_ready (trig_ready),
      .sin_val  (sin_val),
      .cos_val  (cos_val),
      .out_valid(p1_valid),
      .out_ready(p1_ready),
      .prod     (prod),
      .sy       (sy),
      .cz       (cz),
      .sz       (sz)
   );

   logic signed [erm_pkg::OUT_W-1:0] entry [erm_pkg::N_ENTRY];

   erm_prod2 #(
      .FRAC_BITS(FRAC_BITS)
   ) u_prod2 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (p1_valid),
      .in_ready (p1_ready),
      .prod     (prod),
      .sy       (sy),
      .cz       (cz),
      .sz       (sz),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .entry    (entry)
   );

   assign rsp_m_row0_col0 = entry[0];
   assign rsp_m_row0_col1 = entry[1];
   assign rsp_m_row0_col2 = entry[2];
   assign rsp_m_row1_col0 = entry[3];
   assign rsp_m_row1_col1 = entry[4];
   assign rsp_m_row1_col2 = entry[5];
   assign rsp_m_row2_col0 = entry[6];
   assign rsp_m_row2_col1 = entry[7];
   assign rsp_m_row2_col2 = entry[8];

endmodule

FILE: tb/sv/euler_rotation_matrix_tb.sv
// Testbench for the Euler angle rotation matrix: predicts every matrix and checks each result.
`timescale 1ns / 100ps

module euler_rotation_matrix_tb;

   localparam int ANGLE_BITS = 12;
   localparam int FRAC_BITS = 14;
   localparam int QUARTER = 1 << (ANGLE_BITS - 2);
   localparam longint UNIT = longint'(1) << FRAC_BITS;
   localparam logic [63:0] PI_FIX60 = 64'h3243F6A8885A308D;
   localparam int HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT = 300000;

   typedef logic [ANGLE_BITS-1:0] angle_type;
   typedef logic [erm_pkg::N_ENTRY-1:0][erm_pkg::OUT_W-1:0] matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   angle_type req_angle_x = '0;
   angle_type req_angle_y = '0;
   angle_type req_angle_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [erm_pkg::OUT_W-1:0] rsp_m_row0_col0, rsp_m_row0_col1, rsp_m_row0_col2;
   logic signed [erm_pkg::OUT_W-1:0] rsp_m_row1_col0, rsp_m_row1_col1, rsp_m_row1_col2;
   logic signed [erm_pkg::OUT_W-1:0] rsp_m_row2_col0, rsp_m_row2_col1, rsp_m_row2_col2;

   longint quarter_sine [0:QUARTER];
   matrix_type pending_matrices [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic hold_busy = 1'b0;
   event hold_go;

   euler_rotation_matrix #(
      .ANGLE_BITS(ANGLE_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_angle_x    (req_angle_x),
      .req_angle_y    (req_angle_y),
      .req_angle_z    (req_angle_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_m_row0_col0(rsp_m_row0_col0),
      .rsp_m_row0_col1(rsp_m_row0_col1),
      .rsp_m_row0_col2(rsp_m_row0_col2),
      .rsp_m_row1_col0(rsp_m_row1_col0),
      .rsp_m_row1_col1(rsp_m_row1_col1),
      .rsp_m_row1_col2(rsp_m_row1_col2),
      .rsp_m_row2_col0(rsp_m_row2_col0),
      .rsp_m_row2_col1(rsp_m_row2_col1),
      .rsp_m_row2_col2(rsp_m_row2_col2)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic [63:0] fix_mul_shift(logic [63:0] a, logic [63:0] b,
                                                 int unsigned s);
      logic [127:0] full;
      full = {64'd0, a} * {64'd0, b};
      full = full >> s;
      return full[63:0];
   endfunction

   // sine of a first-quadrant angle, 60 fraction bits in and out
   function automatic logic [63:0] series_sine(logic [63:0] x);
      logic [63:0] x_sq;
      logic [63:0] term;
      logic [63:0] acc;
      x_sq = fix_mul_shift(x, x, 60);
      term = x;
      acc = x;
      for (int n = 1; n <= 15; n++) begin
         term = fix_mul_shift(term, x_sq, 60) / 64'(4 * n * n + 2 * n);
         acc = (n % 2 == 1) ? acc - term : acc + term;
      end
      return acc;
   endfunction

   task automatic build_sine_table();
      logic [63:0] theta;
      quarter_sine[0] = 0;
      for (int k = 1; k <= QUARTER; k++) begin
         theta = fix_mul_shift(PI_FIX60, 64'(k), ANGLE_BITS - 1);
         quarter_sine[k] = longint'((series_sine(theta) + (64'd1 << (59 - FRAC_BITS)))
                                    >> (60 - FRAC_BITS));
      end
   endtask

   function automatic longint sine_of(angle_type a);
      logic [1:0] quad;
      int unsigned offset;
      int unsigned k;
      quad = a[ANGLE_BITS-1 -: 2];
      offset = a[ANGLE_BITS-3:0];
      k = quad[0] ? QUARTER - offset : offset;
      return quad[1] ? -quarter_sine[k] : quarter_sine[k];
   endfunction

   function automatic longint cosine_of(angle_type a);
      return sine_of(angle_type'(a + QUARTER));
   endfunction

   // halves round up: floor of (a*b + half) / unit
   function automatic longint round_mul(longint a, longint b);
      return (a * b + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic logic [erm_pkg::OUT_W-1:0] clamp_unit(longint v);
      if (v > UNIT) v = UNIT;
      if (v < -UNIT) v = -UNIT;
      return v[erm_pkg::OUT_W-1:0];
   endfunction

   function automatic matrix_type rotation_of(angle_type ax, angle_type ay, angle_type az);
      matrix_type m;
      longint sx, cx, sy, cy, sz, cz;
      longint sysx, czcx, szcx;
      sx = sine_of(ax);
      cx = cosine_of(ax);
      sy = sine_of(ay);
      cy = cosine_of(ay);
      sz = sine_of(az);
      cz = cosine_of(az);
      sysx = round_mul(sy, sx);
      czcx = round_mul(cz, cx);
      szcx = round_mul(sz, cx);
      m[0] = clamp_unit(round_mul(cz, cy));
      m[1] = clamp_unit(round_mul(cz, sysx) - szcx);
      m[2] = clamp_unit(round_mul(czcx, sy) + round_mul(sz, sx));
      m[3] = clamp_unit(round_mul(sz, cy));
      m[4] = clamp_unit(czcx + round_mul(sz, sysx));
      m[5] = clamp_unit(round_mul(szcx, sy) - round_mul(cz, sx));
      m[6] = clamp_unit(-sy);
      m[7] = clamp_unit(round_mul(cy, sx));
      m[8] = clamp_unit(round_mul(cy, cx));
      return m;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string msg);
      mismatch_count++;
      $display("ERROR cycle %0d: %s", cycle_count, msg);
   endtask

   always @(posedge clock) begin : check_results
      matrix_type got;
      matrix_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_m_row2_col2, rsp_m_row2_col1, rsp_m_row2_col0,
                rsp_m_row1_col2, rsp_m_row1_col1, rsp_m_row1_col0,
                rsp_m_row0_col2, rsp_m_row0_col1, rsp_m_row0_col0};
         if (pending_matrices.size() == 0) begin
            report_mismatch("result item with no input item pending");
         end else begin
            want = pending_matrices.pop_front();
            for (int i = 0; i < erm_pkg::N_ENTRY; i++) begin
               if (got[i] !== want[i])
                  report_mismatch($sformatf("m_row%0d_col%0d got %0d expected %0d",
                                            i / 3, i % 3, $signed(got[i]),
                                            $signed(want[i])));
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (reset || hold_busy) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      forever begin
         @(hold_go);
         hold_busy <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_busy <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_angles(angle_type ax, angle_type ay, angle_type az);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_angle_x <= ax;
      req_angle_y <= ay;
      req_angle_z <= az;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_matrices.push_back(rotation_of(ax, ay, az));
   endtask

   // drop valid and hold until every matrix is back
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_matrices.size() != 0) @(posedge clock);
   endtask

   // mostly uniform, some near the axes and near the octant angles
   function automatic angle_type pick_angle();
      case ($urandom_range(9))
         6, 7: return angle_type'($urandom_range(3) * QUARTER + $urandom_range(4) - 2);
         8, 9: return angle_type'($urandom_range(7) * (QUARTER / 2) + $urandom_range(4) - 2);
         default: return angle_type'($urandom());
      endcase
   endfunction

   task automatic send_random_items(int count, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_angles(pick_angle(), pick_angle(), pick_angle());
      wait_drain();
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_angles(0, 0, 0);
      send_angles(4095, 4095, 4095);
      send_angles(1024, 0, 0);
      send_angles(0, 1024, 0);
      send_angles(0, 0, 1024);
      send_angles(2048, 2048, 2048);
      send_angles(3072, 3072, 3072);
      send_angles(1024, 1024, 1024);
      send_angles(3072, 2048, 1024);
      send_angles(512, 512, 512);
      send_angles(3584, 512, 2560);
      // gimbal lock at y = +-quarter turn
      send_angles(512, 1024, 512);
      send_angles(1536, 3072, 3584);
      send_angles(1, 2047, 4094);
      send_angles(2049, 3071, 1023);
      send_angles(1025, 3073, 2047);
      send_angles(2730, 1365, 341);
      send_angles(511, 513, 1535);
      send_angles(4095, 0, 2048);
      send_angles(3583, 3585, 2559);
      wait_drain();
   endtask

   task automatic test_streaming();
      send_random_items(250, 0, 0);
   endtask

   task automatic test_sender_gaps();
      send_random_items(250, 58, 0);
   endtask

   task automatic test_receiver_stalls();
      send_random_items(250, 0, 58);
   endtask

   task automatic test_both_idle();
      send_random_items(250, 14, 14);
   endtask

   // receiver holds off long enough to fill the pipeline and stall the input
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      -> hold_go;
      repeat (40) send_angles(pick_angle(), pick_angle(), pick_angle());
      wait_drain();
   endtask

   initial begin
      build_sine_table();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_streaming();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_backpressure();
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_matrices.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/erm_pkg.sv
hw/rtl/erm_ram.sv
hw/rtl/erm_lookup.sv
hw/rtl/erm_prod1.sv
hw/rtl/erm_prod2.sv
hw/rtl/euler_rotation_matrix.sv
tb/sv/euler_rotation_matrix_tb.sv
